// ===== rtl/core/spectral_band_signal_detector_top_defines.svh =====
// Assertion macros shared by the detector RTL.
// Expects aclk and aresetn in the scope of each use; no other dependencies.
`ifndef SPECTRAL_BAND_SIGNAL_DETECTOR_TOP_DEFINES_SVH
`define SPECTRAL_BAND_SIGNAL_DETECTOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SBSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SBSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sbsd_pkg.sv =====
// Shared types and constants for the three-band spectral power detector.
// No dependencies; used by sbsd_divider and spectral_band_signal_detector_top.
`default_nettype none

package sbsd_pkg;

    // Frame size default and fixed field widths
    localparam int unsigned FRAME_BINS_DEF = 1024;
    localparam int unsigned POWER_W        = 32;
    localparam int unsigned ACC_W          = 41;
    localparam int unsigned BAND_BINS_W    = 9;
    localparam int unsigned CSTART_W       = 10;
    localparam int unsigned ALPHA_W        = 17;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned PROD_W         = POWER_W + ALPHA_W;
    localparam int unsigned DIV_STEPS      = ACC_W;
    localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

    // Band slots
    localparam int unsigned NUM_BANDS  = 3;
    localparam int unsigned BAND_IDX_W = 2;
    localparam logic [BAND_IDX_W-1:0] BAND_CENTRAL = 2'd0;
    localparam logic [BAND_IDX_W-1:0] BAND_LEFT    = 2'd1;
    localparam logic [BAND_IDX_W-1:0] BAND_RIGHT   = 2'd2;

    // Q1.16 unity and rounding constant
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
    localparam logic [PROD_W-1:0]  IIR_ROUND = 49'd32768;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARRIER_MODE   = 3'd0,
        CFG_AVERAGE_ENABLE = 3'd1,
        CFG_BAND_BINS      = 3'd2,
        CFG_CENTRAL_START  = 3'd3,
        CFG_THRESHOLD      = 3'd4,
        CFG_IIR_ALPHA      = 3'd5
    } cfg_index_t;

    // Divider request and response
    typedef struct packed {
        logic                   start;
        logic [ACC_W-1:0]       dividend;
        logic [BAND_BINS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [POWER_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/spectral_band_signal_detector_top.sv =====
// Three-band spectral power detector.
// Input channel s_* takes one power bin per transaction; s_last_bin closes a frame.
// Result channel m_* gives one transaction per frame: detection flag, start marker
// and the central, left and right band levels used in the decision.
// Config channel cfg_* writes one register per transaction; always ready.
// While accumulating, a bin is taken whenever s_valid is high. After the last bin
// the block drops s_ready and runs a small sequencer over the three bands. In mean
// mode each band is issued to a shared bit-serial divider (ST_LEVEL) and waits for
// its quotient (ST_DIV_WAIT), then passes through ST_FILTER, or with averaging on
// through ST_FILTER, ST_MUL_NEW and ST_SUM on one shared 32x17 multiplier. In peak
// mode or with zero band width the divider is skipped. s_ready stays low until the
// result is written to the output register, including any wait for room there.
// The result sits in an output register; the next frame's bins are taken while it
// waits, and only a second finished result stalls on a full output register.
// Reset returns registers to their defaults, clears accumulators and filter
// state, arms the start marker and empties the output register.
// Writing carrier_mode, average_enable or iir_alpha clears the filter outputs.
`default_nettype none
`include "spectral_band_signal_detector_top_defines.svh"

module spectral_band_signal_detector_top #(
    parameter int unsigned FRAME_BINS = sbsd_pkg::FRAME_BINS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sbsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // bin stream
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [sbsd_pkg::POWER_W-1:0]      s_bin_power,
    input  wire logic                              s_last_bin,
    // per-frame results
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_detected,
    output logic                                   m_start_marker,
    output logic [sbsd_pkg::POWER_W-1:0]           m_central_level,
    output logic [sbsd_pkg::POWER_W-1:0]           m_left_level,
    output logic [sbsd_pkg::POWER_W-1:0]           m_right_level
);
    import sbsd_pkg::*;

    localparam int unsigned PW = $clog2(FRAME_BINS + 1);
    localparam int unsigned CW = ((PW > 11) ? PW : 11) + 1;

    typedef enum logic [6:0] {
        ST_ACCUM    = 7'b0000001,
        ST_LEVEL    = 7'b0000010,
        ST_DIV_WAIT = 7'b0000100,
        ST_FILTER   = 7'b0001000,
        ST_MUL_NEW  = 7'b0010000,
        ST_SUM      = 7'b0100000,
        ST_DECIDE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic                   carrier_reg, carrier_next;
    logic                   avg_en_reg, avg_en_next;
    logic [BAND_BINS_W-1:0] bb_reg, bb_next;
    logic [CSTART_W-1:0]    cs_reg, cs_next;
    logic [POWER_W-1:0]     thr_reg, thr_next;
    logic [ALPHA_W-1:0]     alpha_reg, alpha_next;

    // frame state
    logic [PW-1:0]          pos_reg, pos_next;
    logic [ACC_W-1:0]       acc_reg [NUM_BANDS], acc_next [NUM_BANDS];
    logic [POWER_W-1:0]     avg_reg [NUM_BANDS], avg_next [NUM_BANDS];
    logic [POWER_W-1:0]     lv_reg [NUM_BANDS], lv_next [NUM_BANDS];
    logic                   armed_reg, armed_next;

    // sequencer datapath
    logic [BAND_IDX_W-1:0]  idx_reg, idx_next;
    logic [POWER_W-1:0]     level_reg, level_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [PROD_W-1:0]      sum_reg, sum_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic                   det_reg, det_next;
    logic                   marker_reg, marker_next;
    logic [POWER_W-1:0]     out_lv_reg [NUM_BANDS], out_lv_next [NUM_BANDS];

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic [CW-1:0]          p_w, cs_w, bb_w;
    logic                   in_band [NUM_BANDS];
    logic [ALPHA_W-1:0]     a_eff, a_inv;
    logic [POWER_W-1:0]     mul_a;
    logic [ALPHA_W-1:0]     mul_b;
    logic [PROD_W-1:0]      mul_prod;
    logic [PROD_W-1:0]      iir_sum;
    logic [POWER_W:0]       diff_l, diff_r;
    logic                   det;
    logic [ACC_W-1:0]       x_ext;

    // band membership of the current bin position
    always_comb begin
        p_w  = CW'(pos_reg);
        cs_w = CW'(cs_reg);
        bb_w = CW'(bb_reg);
        in_band[BAND_CENTRAL] = (p_w >= cs_w) && (p_w < cs_w + bb_w);
        in_band[BAND_LEFT]    = (p_w + bb_w + 1'b1 >= cs_w) && (p_w + 1'b1 < cs_w);
        in_band[BAND_RIGHT]   = (p_w >= cs_w + bb_w + 1'b1)
                             && (p_w < cs_w + bb_w + bb_w + 1'b1);
    end

    // shared multiplier: old average times (1 - a), then new level times a
    assign a_eff    = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign a_inv    = ALPHA_ONE - a_eff;
    assign mul_a    = (state_reg == ST_FILTER) ? avg_reg[idx_reg] : level_reg;
    assign mul_b    = (state_reg == ST_FILTER) ? a_inv : a_eff;
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign iir_sum  = sum_reg + prod_reg;

    // detection: central above each side by more than threshold
    assign diff_l = {1'b0, lv_reg[BAND_CENTRAL]} - {1'b0, lv_reg[BAND_LEFT]};
    assign diff_r = {1'b0, lv_reg[BAND_CENTRAL]} - {1'b0, lv_reg[BAND_RIGHT]};
    assign det    = !diff_l[POWER_W] && (diff_l[POWER_W-1:0] > thr_reg)
                 && !diff_r[POWER_W] && (diff_r[POWER_W-1:0] > thr_reg);

    assign x_ext = ACC_W'(s_bin_power);

    // divider request
    assign div_req.start    = (state_reg == ST_LEVEL) && !carrier_reg && (bb_reg != '0);
    assign div_req.dividend = acc_reg[idx_reg];
    assign div_req.divisor  = bb_reg;

    sbsd_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer and register updates
    always_comb begin
        state_next   = state_reg;
        carrier_next = carrier_reg;
        avg_en_next  = avg_en_reg;
        bb_next      = bb_reg;
        cs_next      = cs_reg;
        thr_next     = thr_reg;
        alpha_next   = alpha_reg;
        pos_next     = pos_reg;
        armed_next   = armed_reg;
        idx_next     = idx_reg;
        level_next   = level_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg;
        det_next     = det_reg;
        marker_next  = marker_reg;
        for (int b = 0; b < NUM_BANDS; b++) begin
            acc_next[b]    = acc_reg[b];
            avg_next[b]    = avg_reg[b];
            lv_next[b]     = lv_reg[b];
            out_lv_next[b] = out_lv_reg[b];
        end

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_ACCUM: begin
                if (s_valid) begin
                    if (pos_reg < PW'(FRAME_BINS)) begin
                        for (int b = 0; b < NUM_BANDS; b++) begin
                            if (in_band[b]) begin
                                if (carrier_reg) begin
                                    if (x_ext > acc_reg[b]) begin
                                        acc_next[b] = x_ext;
                                    end
                                end else begin
                                    acc_next[b] = acc_reg[b] + x_ext;
                                end
                            end
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                    if (s_last_bin) begin
                        idx_next   = BAND_CENTRAL;
                        state_next = ST_LEVEL;
                    end
                end
            end
            ST_LEVEL: begin
                if (carrier_reg) begin
                    level_next = acc_reg[idx_reg][POWER_W-1:0];
                    state_next = ST_FILTER;
                end else if (bb_reg == '0) begin
                    level_next = '0;
                    state_next = ST_FILTER;
                end else begin
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    level_next = div_rsp.quotient;
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER: begin
                if (avg_en_reg) begin
                    prod_next  = mul_prod;
                    state_next = ST_MUL_NEW;
                end else begin
                    lv_next[idx_reg] = level_reg;
                    if (idx_reg == BAND_RIGHT) begin
                        state_next = ST_DECIDE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_LEVEL;
                    end
                end
            end
            ST_MUL_NEW: begin
                sum_next   = prod_reg + IIR_ROUND;
                prod_next  = mul_prod;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                avg_next[idx_reg] = iir_sum[POWER_W+15:16];
                lv_next[idx_reg]  = iir_sum[POWER_W+15:16];
                if (idx_reg == BAND_RIGHT) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_LEVEL;
                end
            end
            ST_DECIDE: begin
                // wait for room in the output register
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    det_next     = det;
                    marker_next  = det && armed_reg;
                    armed_next   = !det;
                    for (int b = 0; b < NUM_BANDS; b++) begin
                        out_lv_next[b] = lv_reg[b];
                        acc_next[b]    = '0;
                    end
                    pos_next   = '0;
                    state_next = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase

        // configuration writes
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CARRIER_MODE: begin
                    carrier_next = cfg_data[0];
                    for (int b = 0; b < NUM_BANDS; b++) avg_next[b] = '0;
                end
                CFG_AVERAGE_ENABLE: begin
                    avg_en_next = cfg_data[0];
                    for (int b = 0; b < NUM_BANDS; b++) avg_next[b] = '0;
                end
                CFG_BAND_BINS:     bb_next  = cfg_data[BAND_BINS_W-1:0];
                CFG_CENTRAL_START: cs_next  = cfg_data[CSTART_W-1:0];
                CFG_THRESHOLD:     thr_next = cfg_data[POWER_W-1:0];
                CFG_IIR_ALPHA: begin
                    alpha_next = cfg_data[ALPHA_W-1:0];
                    for (int b = 0; b < NUM_BANDS; b++) avg_next[b] = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            carrier_reg <= 1'b0;
            avg_en_reg  <= 1'b0;
            bb_reg      <= BAND_BINS_W'(16);
            cs_reg      <= CSTART_W'(496);
            thr_reg     <= POWER_W'(65536);
            alpha_reg   <= ALPHA_W'(6554);
            pos_reg     <= '0;
            armed_reg   <= 1'b1;
            idx_reg     <= BAND_CENTRAL;
            m_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BANDS; b++) begin
                acc_reg[b] <= '0;
                avg_reg[b] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            carrier_reg <= carrier_next;
            avg_en_reg  <= avg_en_next;
            bb_reg      <= bb_next;
            cs_reg      <= cs_next;
            thr_reg     <= thr_next;
            alpha_reg   <= alpha_next;
            pos_reg     <= pos_next;
            armed_reg   <= armed_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            for (int b = 0; b < NUM_BANDS; b++) begin
                acc_reg[b] <= acc_next[b];
                avg_reg[b] <= avg_next[b];
            end
        end
        level_reg  <= level_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        det_reg    <= det_next;
        marker_reg <= marker_next;
        for (int b = 0; b < NUM_BANDS; b++) begin
            lv_reg[b]     <= lv_next[b];
            out_lv_reg[b] <= out_lv_next[b];
        end
    end

    // ports
    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == ST_ACCUM);
    assign m_valid         = m_valid_reg;
    assign m_detected      = det_reg;
    assign m_start_marker  = marker_reg;
    assign m_central_level = out_lv_reg[BAND_CENTRAL];
    assign m_left_level    = out_lv_reg[BAND_LEFT];
    assign m_right_level   = out_lv_reg[BAND_RIGHT];

    `SBSD_ASSERT_NEXT(a_last_bin_stalls, s_valid && s_ready && s_last_bin, !s_ready, "input open after frame end")
    `SBSD_ASSERT_SAME(a_marker_needs_det, m_valid, !m_start_marker || m_detected, "marker without detection")
    `SBSD_ASSERT_SAME(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `SBSD_ASSERT_SAME(a_band_idx_range, state_reg != ST_ACCUM, idx_reg != 2'd3, "band index out of range")

endmodule

`default_nettype wire

// ===== rtl/core/sbsd_divider.sv =====
// Bit-serial restoring divider: 41-bit accumulator by 9-bit band width.
// Depends on sbsd_pkg and the assertion macro header.
`default_nettype none
`include "spectral_band_signal_detector_top_defines.svh"

module sbsd_divider (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sbsd_pkg::div_req_t req,
    output sbsd_pkg::div_rsp_t      rsp
);
    import sbsd_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   count_reg, count_next;
    logic [BAND_BINS_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0]       quot_reg, quot_next;
    logic [BAND_BINS_W-1:0] divisor_reg, divisor_next;

    logic [BAND_BINS_W:0]   shifted;
    logic                   ge;

    // One quotient bit per cycle, MSB first
    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;

        shifted = {rem_reg, quot_reg[ACC_W-1]};
        ge      = shifted >= {1'b0, divisor_reg};

        if (req.start) begin
            busy_next    = 1'b1;
            count_next   = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next     = '0;
            quot_next    = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? BAND_BINS_W'(shifted - {1'b0, divisor_reg})
                           : shifted[BAND_BINS_W-1:0];
            quot_next = {quot_reg[ACC_W-2:0], ge};
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg[POWER_W-1:0];

    `SBSD_ASSERT_NEXT(a_div_start_busy, req.start, rsp.busy, "divider did not start")
    `SBSD_ASSERT_NEXT(a_div_done_pulse, rsp.done, !rsp.done, "divider done held")
    `SBSD_ASSERT_SAME(a_div_done_idle, rsp.done, !rsp.busy, "divider done while busy")

endmodule

`default_nettype wire

// ===== bench/spectral_band_signal_detector_checker.sv =====
`timescale 1ns / 100ps
// Result checker for spectral_band_signal_detector_top: follows config writes and
// accepted bins, predicts each frame result and compares it with the m_* transaction.
// Depends on sbsd_pkg only.
module spectral_band_signal_detector_checker #(
    parameter int unsigned FRAME_BINS = sbsd_pkg::FRAME_BINS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [sbsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic [sbsd_pkg::POWER_W-1:0]      s_bin_power,
    input  wire logic                              s_last_bin,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic                              m_detected,
    input  wire logic                              m_start_marker,
    input  wire logic [sbsd_pkg::POWER_W-1:0]      m_central_level,
    input  wire logic [sbsd_pkg::POWER_W-1:0]      m_left_level,
    input  wire logic [sbsd_pkg::POWER_W-1:0]      m_right_level,
    output int                                     mismatch_count,
    output int                                     frames_pending
);
    import sbsd_pkg::*;

    typedef struct packed {
        logic               detected;
        logic               start_marker;
        logic [POWER_W-1:0] central;
        logic [POWER_W-1:0] left;
        logic [POWER_W-1:0] right;
    } frame_result_t;

    frame_result_t expected_frames[$];

    // register copies
    logic                   is_peak;
    logic                   filt_on;
    logic [BAND_BINS_W-1:0] band_width;
    logic [CSTART_W-1:0]    cen_start;
    logic [POWER_W-1:0]     margin;
    logic [ALPHA_W-1:0]     alpha_q16;

    // frame and filter state
    int unsigned            pos_in_frame;
    logic [ACC_W-1:0]       band_sum  [NUM_BANDS];
    logic [POWER_W-1:0]     band_filt [NUM_BANDS];
    logic                   marker_armed;

    function automatic void drop_filters();
        for (int b = 0; b < NUM_BANDS; b++) band_filt[b] = '0;
    endfunction

    function automatic void reset_model();
        is_peak      = 1'b0;
        filt_on      = 1'b0;
        band_width   = 16;
        cen_start    = 496;
        margin       = 65536;
        alpha_q16    = 6554;
        pos_in_frame = 0;
        for (int b = 0; b < NUM_BANDS; b++) band_sum[b] = '0;
        drop_filters();
        marker_armed = 1'b1;
    endfunction

    function automatic void write_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CARRIER_MODE: begin
                is_peak = data[0];
                drop_filters();
            end
            CFG_AVERAGE_ENABLE: begin
                filt_on = data[0];
                drop_filters();
            end
            CFG_BAND_BINS:     band_width = data[BAND_BINS_W-1:0];
            CFG_CENTRAL_START: cen_start = data[CSTART_W-1:0];
            CFG_THRESHOLD:     margin = data[POWER_W-1:0];
            CFG_IIR_ALPHA: begin
                alpha_q16 = data[ALPHA_W-1:0];
                drop_filters();
            end
            default: ;
        endcase
    endfunction

    // peak or running sum, depending on the mode at the time of the bin
    function automatic void take_bin(input int band, input logic [POWER_W-1:0] x);
        logic [ACC_W-1:0] wide;
        wide = x;
        if (is_peak) begin
            if (wide > band_sum[band]) band_sum[band] = wide;
        end else begin
            band_sum[band] = band_sum[band] + wide;
        end
    endfunction

    function automatic logic [POWER_W-1:0] band_readout(input int band);
        logic [ACC_W-1:0] quot;
        if (is_peak) return band_sum[band][POWER_W-1:0];
        if (band_width == 0) return '0;
        quot = band_sum[band] / band_width;
        return quot[POWER_W-1:0];
    endfunction

    // single-pole filter, alpha saturated at one, rounded half up
    function automatic logic [POWER_W-1:0] iir_update(input int band,
                                                      input logic [POWER_W-1:0] x);
        logic [63:0] a;
        logic [63:0] unity;
        logic [63:0] acc;
        unity = ALPHA_ONE;
        a = (alpha_q16 > ALPHA_ONE) ? unity : alpha_q16;
        acc = band_filt[band] * (unity - a) + x * a + 64'd32768;
        band_filt[band] = acc[47:16];
        return band_filt[band];
    endfunction

    function automatic void accept_bin(input logic [POWER_W-1:0] x, input logic last);
        int unsigned p;
        int unsigned cs;
        int unsigned bb;
        logic [POWER_W-1:0] lvl [NUM_BANDS];
        frame_result_t res;
        logic det;
        if (pos_in_frame < FRAME_BINS) begin
            p  = pos_in_frame;
            cs = cen_start;
            bb = band_width;
            if (p >= cs && p < cs + bb) take_bin(BAND_CENTRAL, x);
            if (p + bb + 1 >= cs && p + 1 < cs) take_bin(BAND_LEFT, x);
            if (p >= cs + bb + 1 && p < cs + 2 * bb + 1) take_bin(BAND_RIGHT, x);
            pos_in_frame++;
        end
        if (!last) return;

        for (int b = 0; b < NUM_BANDS; b++) begin
            lvl[b] = band_readout(b);
            if (filt_on) lvl[b] = iir_update(b, lvl[b]);
        end
        det = lvl[BAND_CENTRAL] > lvl[BAND_LEFT] &&
              (lvl[BAND_CENTRAL] - lvl[BAND_LEFT]) > margin &&
              lvl[BAND_CENTRAL] > lvl[BAND_RIGHT] &&
              (lvl[BAND_CENTRAL] - lvl[BAND_RIGHT]) > margin;
        res.detected     = det;
        res.start_marker = det && marker_armed;
        res.central      = lvl[BAND_CENTRAL];
        res.left         = lvl[BAND_LEFT];
        res.right        = lvl[BAND_RIGHT];
        marker_armed     = !det;
        expected_frames.push_back(res);

        pos_in_frame = 0;
        for (int b = 0; b < NUM_BANDS; b++) band_sum[b] = '0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [POWER_W-1:0] want,
                                 input logic [POWER_W-1:0] got);
        if (mismatch_count < 100)
            $display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            reset_model();
            expected_frames.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    flag_mismatch("result with no frame pending", '0, m_central_level);
                end else begin
                    want = expected_frames.pop_front();
                    if (m_detected !== want.detected)
                        flag_mismatch("detected", want.detected, m_detected);
                    if (m_start_marker !== want.start_marker)
                        flag_mismatch("start_marker", want.start_marker, m_start_marker);
                    if (m_central_level !== want.central)
                        flag_mismatch("central_level", want.central, m_central_level);
                    if (m_left_level !== want.left)
                        flag_mismatch("left_level", want.left, m_left_level);
                    if (m_right_level !== want.right)
                        flag_mismatch("right_level", want.right, m_right_level);
                end
            end
            if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
            if (s_valid && s_ready) accept_bin(s_bin_power, s_last_bin);
        end
        frames_pending <= expected_frames.size();
    end

endmodule

// ===== bench/spectral_band_signal_detector_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for spectral_band_signal_detector_top: makes config writes, bin
// frames and result back-pressure, then gives the verdict.
// Depends on sbsd_pkg, the detector RTL and spectral_band_signal_detector_checker.
module spectral_band_signal_detector_top_tb;
    import sbsd_pkg::*;

    localparam int unsigned FRAME_LEN    = FRAME_BINS_DEF;
    localparam int unsigned RAND_ITEMS   = 1500;
    localparam int unsigned MIN_FRAMES   = 20;
    localparam int unsigned REST_CYCLES  = 160;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned NUM_REGS     = 6;
    localparam int          FAR_PHASE    = 3;
    localparam int          STEADY_PHASE = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [POWER_W-1:0]    s_bin_power = '0;
    logic                  s_last_bin  = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_detected;
    logic                  m_start_marker;
    logic [POWER_W-1:0]    m_central_level;
    logic [POWER_W-1:0]    m_left_level;
    logic [POWER_W-1:0]    m_right_level;

    int          mismatch_count;
    int          frames_pending;
    int          cycle_count = 0;
    int unsigned items_sent  = 0;
    int unsigned frames_sent = 0;
    int unsigned cur_bb      = 16;
    int unsigned cur_cs      = 496;
    bit          steady      = 1'b0;

    spectral_band_signal_detector_top #(
        .FRAME_BINS(FRAME_LEN)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_bin_power    (s_bin_power),
        .s_last_bin     (s_last_bin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_detected     (m_detected),
        .m_start_marker (m_start_marker),
        .m_central_level(m_central_level),
        .m_left_level   (m_left_level),
        .m_right_level  (m_right_level)
    );

    spectral_band_signal_detector_checker #(
        .FRAME_BINS(FRAME_LEN)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_bin_power    (s_bin_power),
        .s_last_bin     (s_last_bin),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_detected     (m_detected),
        .m_start_marker (m_start_marker),
        .m_central_level(m_central_level),
        .m_left_level   (m_left_level),
        .m_right_level  (m_right_level),
        .mismatch_count (mismatch_count),
        .frames_pending (frames_pending)
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL spectral_band_signal_detector_top");
            $finish;
        end
    end

    // result back-pressure, about a third of cycles stalled
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 32);
    end

    // one config transaction; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        int unsigned used_w;
        data = value;
        case (idx)
            CFG_CARRIER_MODE, CFG_AVERAGE_ENABLE: used_w = 1;
            CFG_BAND_BINS:     used_w = BAND_BINS_W;
            CFG_CENTRAL_START: used_w = CSTART_W;
            CFG_IIR_ALPHA:     used_w = ALPHA_W;
            default:           used_w = CFG_DATA_W;
        endcase
        // bits above a narrow register are don't-care
        if (used_w < CFG_DATA_W && $urandom_range(0, 3) == 0)
            data = data | ($urandom << used_w);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // one bin transaction, sometimes with a random gap ahead of it
    task automatic send_bin(input logic [POWER_W-1:0] power, input logic last);
        if (!steady && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 32);
        end
        s_valid     <= 1'b1;
        s_bin_power <= power;
        s_last_bin  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // stop sending and wait for every pending frame result
    task automatic drain_results(input bit then_rest);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frames_pending != 0) @(posedge aclk);
        if (then_rest) repeat (REST_CYCLES) @(posedge aclk);
    endtask

    // pick and write one register setting; block is idle here
    task automatic program_phase(input int phase);
        logic                   mode;
        logic                   avg;
        logic [BAND_BINS_W-1:0] bb;
        logic [CSTART_W-1:0]    cs;
        logic [POWER_W-1:0]     thr;
        logic [ALPHA_W-1:0]     alpha;
        int unsigned            first;
        cfg_index_t             idx;
        mode = $urandom_range(0, 1);
        avg  = $urandom_range(0, 1);
        bb   = ($urandom_range(0, 9) == 0) ? '0 : BAND_BINS_W'($urandom_range(1, 12));
        cs   = $urandom_range(0, 40);
        case ($urandom_range(0, 4))
            0:       thr = '0;
            1:       thr = $urandom_range(0, 65535);
            2:       thr = $urandom >> $urandom_range(0, 31);
            3:       thr = '1;
            default: thr = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       alpha = '0;
            1:       alpha = ALPHA_ONE;
            2:       alpha = $urandom_range(1, 65535);
            3:       alpha = $urandom_range(65537, 131071);
            default: alpha = $urandom_range(1000, 30000);
        endcase
        // corner settings on fixed phases
        if (phase == 0) begin
            mode = 1'b0; avg = 1'b0; bb = 1; cs = '0; thr = '0; alpha = '0;
        end
        if (phase == 1) begin
            mode = 1'b1; avg = 1'b1; bb = 12; cs = 40; thr = '1; alpha = '1;
        end
        if (phase == FAR_PHASE) begin
            bb = $urandom_range(0, 1) ? BAND_BINS_W'(341) : '1;
            cs = $urandom_range(0, 1) ? CSTART_W'($urandom_range(900, 1022)) : '1;
        end

        first = $urandom_range(0, NUM_REGS - 1);
        for (int k = 0; k < NUM_REGS; k++) begin
            idx = cfg_index_t'((first + k) % NUM_REGS);
            if (phase > 1 && phase != FAR_PHASE && phase != FAR_PHASE + 1 &&
                $urandom_range(0, 4) == 0)
                continue;
            case (idx)
                CFG_CARRIER_MODE:   write_reg(idx, mode);
                CFG_AVERAGE_ENABLE: write_reg(idx, avg);
                CFG_BAND_BINS: begin
                    write_reg(idx, bb);
                    cur_bb = bb;
                end
                CFG_CENTRAL_START: begin
                    write_reg(idx, cs);
                    cur_cs = cs;
                end
                CFG_THRESHOLD:      write_reg(idx, thr);
                default:            write_reg(idx, alpha);
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // one frame: mostly covering all three bands, some short ones
    task automatic send_frame(input bit far);
        int unsigned len;
        int unsigned span;
        bit          tone;
        bit          in_central;
        logic [POWER_W-1:0] pw;
        span = cur_cs + 2 * cur_bb + 1;
        if (far) begin
            len = $urandom_range(1000, 1060);
        end else begin
            case ($urandom_range(0, 9))
                0:       len = 1;
                1, 2:    len = $urandom_range(1, span);
                default: len = span + $urandom_range(0, 4);
            endcase
        end
        tone = $urandom_range(0, 99) < 60;
        for (int unsigned p = 0; p < len; p++) begin
            in_central = p >= cur_cs && p < cur_cs + cur_bb;
            case ($urandom_range(0, 15))
                0:       pw = '0;
                1:       pw = '1;
                default: begin
                    if (!tone)          pw = $urandom;
                    else if (in_central) pw = $urandom | 32'h8000_0000;
                    else                pw = $urandom >> $urandom_range(1, 31);
                end
            endcase
            send_bin(pw, p == len - 1);
        end
        frames_sent++;
    endtask

    initial begin
        int phase;
        int nfr;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // mean mode, bands of two: left 0-1, central 3-4, right 6-7
        write_reg(CFG_CARRIER_MODE, 0);
        write_reg(CFG_AVERAGE_ENABLE, 0);
        write_reg(CFG_BAND_BINS, 2);
        write_reg(CFG_CENTRAL_START, 3);
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_IIR_ALPHA, ALPHA_ONE);
        cfg_valid <= 1'b0;
        // two detected frames at full scale: marker only on the first
        repeat (2) begin
            send_bin('0, 1'b0); send_bin('0, 1'b0); send_bin('1, 1'b0);
            send_bin('1, 1'b0); send_bin('1, 1'b0); send_bin('1, 1'b0);
            send_bin('0, 1'b0); send_bin('0, 1'b0); send_bin('1, 1'b1);
        end
        // one-bin frame: only the left band sees a bin, no detection, re-arms the marker
        send_bin('1, 1'b1);

        // zero band width in peak mode with the largest margin
        drain_results(1);
        write_reg(CFG_CARRIER_MODE, 1);
        write_reg(CFG_BAND_BINS, 0);
        write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_bin('1, 1'b0);
        send_bin('1, 1'b1);

        // left band wholly below bin zero, filter on with alpha above one
        drain_results(1);
        write_reg(CFG_BAND_BINS, 1);
        write_reg(CFG_CENTRAL_START, 0);
        write_reg(CFG_AVERAGE_ENABLE, 1);
        write_reg(CFG_IIR_ALPHA, 17'h1FFFF);
        cfg_valid <= 1'b0;
        send_bin('1, 1'b0);
        send_bin(32'd5, 1'b0);
        send_bin(32'd7, 1'b1);

        // random phases, each with its own register setting
        items_sent = 0;
        phase = 0;
        while (items_sent < RAND_ITEMS || frames_sent < MIN_FRAMES) begin
            drain_results(1);
            steady = (phase == STEADY_PHASE || phase == STEADY_PHASE + 1);
            program_phase(phase);
            nfr = (phase == FAR_PHASE) ? 1 : $urandom_range(3, 10);
            for (int f = 0; f < nfr; f++) begin
                if ($urandom_range(0, 7) == 0) drain_results(0);
                send_frame(phase == FAR_PHASE);
            end
            phase++;
        end
        steady = 1'b0;

        drain_results(1);
        if (mismatch_count == 0) begin
            $display("PASS spectral_band_signal_detector_top");
        end else begin
            $display("FAIL spectral_band_signal_detector_top");
        end
        $finish;
    end

endmodule
